### design/leg_fk_pkg.sv
// shared types, constants and fixed-point helpers for the leg kinematics block
// no dependencies

package leg_fk_pkg;

    localparam int N_OUT = 11;
    localparam int OUT_W = 19;
    localparam int IN_TDATA_W = 48;
    localparam int OUT_TDATA_W = 216;

    localparam logic [0:0] REG_LINK_LENGTH = 1'b0;
    localparam logic [0:0] REG_HIP_OFFSET  = 1'b1;
    localparam logic [15:0] LINK_LENGTH_RST = 16'd16384;
    localparam logic [15:0] HIP_OFFSET_RST  = 16'd6554;

    // pi in Q30
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic [30:0] Q_ONE  = 31'h4000_0000;
    localparam logic [13:0] HALF_QUAD = 14'd8192;
    localparam logic [14:0] FULL_QUAD = 15'd16384;

    // reciprocals, scaled by 2^36 and rounded up; exact floor for inputs below 2^30
    localparam longint unsigned RSH = 36;
    localparam logic [33:0] M_DIV6  = 34'(((64'd1 << RSH) + 64'd5) / 64'd6);
    localparam logic [33:0] M_DIV12 = 34'(((64'd1 << RSH) + 64'd11) / 64'd12);
    localparam logic [33:0] M_DIV20 = 34'(((64'd1 << RSH) + 64'd19) / 64'd20);
    localparam logic [33:0] M_DIV30 = 34'(((64'd1 << RSH) + 64'd29) / 64'd30);
    localparam logic [33:0] M_DIV42 = 34'(((64'd1 << RSH) + 64'd41) / 64'd42);
    localparam logic [33:0] M_DIV56 = 34'(((64'd1 << RSH) + 64'd55) / 64'd56);

    localparam logic signed [18:0] OUT_MAX = 19'sd262143;
    localparam logic signed [18:0] OUT_MIN = -19'sd262144;

    typedef struct packed {
        logic signed [31:0] s;
        logic signed [31:0] c;
    } t_sc;

    typedef logic [N_OUT-1:0][OUT_W-1:0] t_res;

    // (a * b) >> 30, a below 2^30 and b at most 2^30
    function automatic logic [29:0] mul30(input logic [29:0] a, input logic [30:0] b);
        logic [60:0] p;
        p = 61'(a) * 61'(b);
        return p[59:30];
    endfunction

    // floor(v / d) through the scaled reciprocal m of d
    function automatic logic [29:0] divc(input logic [29:0] v, input logic [33:0] m);
        logic [63:0] p;
        p = 64'(v) * 64'(m);
        return 30'(p >> RSH);
    endfunction

    // divide by 2^30, round half away from zero
    function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
        logic signed [63:0] h;
        h = 64'sd536870912;
        if (v >= 0) begin
            return (v + h) >>> 30;
        end
        return -((-v + h) >>> 30);
    endfunction

    function automatic logic [18:0] sat19(input logic signed [63:0] v);
        if (v > 64'(OUT_MAX)) begin
            return OUT_MAX;
        end
        if (v < 64'(OUT_MIN)) begin
            return OUT_MIN;
        end
        return v[18:0];
    endfunction

endpackage

### design/leg_forward_kinematics_jacobian_unit.sv
// Three-joint leg forward kinematics and Jacobian, a single stalling pipeline.
//
// Slave stream carries one set of joint angles per transfer, master stream one
// result per transfer. The config channel writes link_length (index 0) and
// hip_offset (index 1); it is always ready and may be written only while idle.
//
// There are 17 register stages from input transfer to output valid: one angle
// register, ten stages of the sine/cosine units, six stages of scaling.
// Throughput is one set per cycle while the output is not stalled.
// The whole pipeline advances together: s_axis_tready is high whenever the
// output register is empty or m_axis_tready is high, so a stalled receiver
// freezes every stage in place and nothing is dropped or repeated.
// At reset all valid bits clear and both lengths return to their reset
// values (16384 and 6554).
// Depends on leg_fk_pkg, leg_fk_trig and leg_fk_comb.

module leg_forward_kinematics_jacobian_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // abduction_angle [15:0], hip_angle [31:16], knee_angle [47:32]
    input  logic [leg_fk_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // foot_x, foot_y, foot_z, jac_x_hip, jac_x_knee, jac_y_abduction, jac_y_hip,
    // jac_y_knee, jac_z_abduction, jac_z_hip, jac_z_knee; 19 bits each, zero pad
    output logic [leg_fk_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [0:0]                          i_cfg_addr,
    input  logic [15:0]                         i_cfg_data
);
    import leg_fk_pkg::*;

    localparam int DEPTH = 17;

    logic [DEPTH-1:0] r_vld;
    logic [15:0]      r_link_length, r_hip_offset;
    logic [15:0]      r_a0, r_a1, r_a12;
    logic             en;
    t_sc              sc0, sc1, sc12;
    t_res             res;

    assign en            = !r_vld[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[DEPTH-1];
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld         <= '0;
            r_link_length <= LINK_LENGTH_RST;
            r_hip_offset  <= HIP_OFFSET_RST;
        end else begin
            if (en) begin
                r_vld <= {r_vld[DEPTH-2:0], s_axis_tvalid};
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_addr)
                    REG_LINK_LENGTH: r_link_length <= i_cfg_data;
                    REG_HIP_OFFSET:  r_hip_offset  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // hip plus knee wraps round the circle
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a0  <= s_axis_tdata[15:0];
            r_a1  <= s_axis_tdata[31:16];
            r_a12 <= s_axis_tdata[31:16] + s_axis_tdata[47:32];
        end
    end

    leg_fk_trig u_trig0 (.i_clk(i_clk), .i_en(en), .i_angle(r_a0),  .o_sc(sc0));
    leg_fk_trig u_trig1 (.i_clk(i_clk), .i_en(en), .i_angle(r_a1),  .o_sc(sc1));
    leg_fk_trig u_trig2 (.i_clk(i_clk), .i_en(en), .i_angle(r_a12), .o_sc(sc12));

    leg_fk_comb u_comb (
        .i_clk         (i_clk),
        .i_en          (en),
        .i_link_length (r_link_length),
        .i_hip_offset  (r_hip_offset),
        .i_sc0         (sc0),
        .i_sc1         (sc1),
        .i_sc12        (sc12),
        .o_res         (res)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - N_OUT*OUT_W)'(0), res};

endmodule

### design/leg_fk_trig.sv
// pipelined sine/cosine of one 16-bit angle, polynomial on a folded octant
// depends on leg_fk_pkg

module leg_fk_trig (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [15:0]         i_angle,
    output leg_fk_pkg::t_sc     o_sc
);
    import leg_fk_pkg::*;

    logic [13:0] r1_t;
    logic [1:0]  r_q  [1:9];
    logic        r_sw [1:9];
    logic [29:0] r_x  [2:8];
    logic [29:0] r_x2 [3:8];
    logic [30:0] r4_ks, r4_kc, r6_ks, r6_kc, r8_ks, r8_kc;
    logic [29:0] r5_ps, r5_pc, r7_ps, r7_pc;
    logic [30:0] r9_s, r9_c;
    t_sc         r_sc;

    logic [13:0] fold_r;
    logic        fold_sw;
    logic [45:0] x_prod;
    logic [59:0] x2_prod;
    logic [29:0] c_prod;
    logic [30:0] sr, cr;

    assign fold_r  = i_angle[13:0];
    assign fold_sw = fold_r > HALF_QUAD;
    assign x_prod  = 46'(r1_t) * 46'(PI_Q30);
    assign x2_prod = 60'(r_x[2]) * 60'(r_x[2]);
    assign c_prod  = mul30(r_x2[8], r8_kc);
    assign sr = r_sw[9] ? r9_c : r9_s;
    assign cr = r_sw[9] ? r9_s : r9_c;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_t    <= fold_sw ? 14'(FULL_QUAD - 15'(fold_r)) : fold_r;
            r_q[1]  <= i_angle[15:14];
            r_sw[1] <= fold_sw;
            for (int i = 2; i <= 9; i++) begin
                r_q[i]  <= r_q[i-1];
                r_sw[i] <= r_sw[i-1];
            end
            r_x[2] <= x_prod[44:15];
            for (int i = 3; i <= 8; i++) begin
                r_x[i] <= r_x[i-1];
            end
            r_x2[3] <= x2_prod[59:30];
            for (int i = 4; i <= 8; i++) begin
                r_x2[i] <= r_x2[i-1];
            end
            r4_ks <= Q_ONE - {1'b0, divc(r_x2[3], M_DIV42)};
            r4_kc <= Q_ONE - {1'b0, divc(r_x2[3], M_DIV56)};
            r5_ps <= mul30(r_x2[4], r4_ks);
            r5_pc <= mul30(r_x2[4], r4_kc);
            r6_ks <= Q_ONE - {1'b0, divc(r5_ps, M_DIV20)};
            r6_kc <= Q_ONE - {1'b0, divc(r5_pc, M_DIV30)};
            r7_ps <= mul30(r_x2[6], r6_ks);
            r7_pc <= mul30(r_x2[6], r6_kc);
            r8_ks <= Q_ONE - {1'b0, divc(r7_ps, M_DIV6)};
            r8_kc <= Q_ONE - {1'b0, divc(r7_pc, M_DIV12)};
            r9_s  <= {1'b0, mul30(r_x[8], r8_ks)};
            r9_c  <= Q_ONE - {2'b0, c_prod[29:1]};
            // quadrant symmetry
            case (r_q[9])
                2'd0: begin
                    r_sc.s <= 32'(sr);
                    r_sc.c <= 32'(cr);
                end
                2'd1: begin
                    r_sc.s <= 32'(cr);
                    r_sc.c <= -32'(sr);
                end
                2'd2: begin
                    r_sc.s <= -32'(sr);
                    r_sc.c <= -32'(cr);
                end
                default: begin
                    r_sc.s <= -32'(cr);
                    r_sc.c <= 32'(sr);
                end
            endcase
        end
    end

    assign o_sc = r_sc;

endmodule

### design/leg_fk_comb.sv
// combines the three sine/cosine pairs with the link lengths into position and jacobian
// depends on leg_fk_pkg

module leg_fk_comb (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [15:0]         i_link_length,
    input  logic [15:0]         i_hip_offset,
    input  leg_fk_pkg::t_sc     i_sc0,
    input  leg_fk_pkg::t_sc     i_sc1,
    input  leg_fk_pkg::t_sc     i_sc12,
    output leg_fk_pkg::t_res    o_res
);
    import leg_fk_pkg::*;

    logic signed [16:0] len_l, len_h;
    assign len_l = signed'({1'b0, i_link_length});
    assign len_h = signed'({1'b0, i_hip_offset});

    // stage 1: sums
    logic signed [32:0] r1_bs, r1_bc;
    logic signed [31:0] r1_s0, r1_c0, r1_s12, r1_c12;
    // stage 2: trig products
    logic signed [63:0] r2_s0S, r2_c0S, r2_s0C, r2_s0c12, r2_c0C, r2_c0c12;
    logic signed [32:0] r2_bs, r2_bc;
    logic signed [31:0] r2_s0, r2_c0, r2_s12;
    // stage 3: rounded to Q30
    logic signed [32:0] r3_s0S, r3_c0S, r3_s0C, r3_s0c12, r3_c0C, r3_c0c12;
    logic signed [32:0] r3_bs, r3_bc;
    logic signed [31:0] r3_s0, r3_c0, r3_s12;
    // stage 4: length products
    logic signed [49:0] r4_lc, r4_ls, r4_ls12, r4_ls0S, r4_lc0S, r4_ls0C;
    logic signed [49:0] r4_ls0c12, r4_lc0C, r4_lc0c12, r4_hc0, r4_hs0;
    // stage 5: sums per output
    logic signed [50:0] r5_sum [N_OUT];
    t_res               r_res;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_bs  <= 33'(i_sc1.s) + 33'(i_sc12.s);
            r1_bc  <= 33'(i_sc1.c) + 33'(i_sc12.c);
            r1_s0  <= i_sc0.s;
            r1_c0  <= i_sc0.c;
            r1_s12 <= i_sc12.s;
            r1_c12 <= i_sc12.c;

            r2_s0S   <= 64'(r1_s0) * 64'(r1_bs);
            r2_c0S   <= 64'(r1_c0) * 64'(r1_bs);
            r2_s0C   <= 64'(r1_s0) * 64'(r1_bc);
            r2_s0c12 <= 64'(r1_s0) * 64'(r1_c12);
            r2_c0C   <= 64'(r1_c0) * 64'(r1_bc);
            r2_c0c12 <= 64'(r1_c0) * 64'(r1_c12);
            r2_bs    <= r1_bs;
            r2_bc    <= r1_bc;
            r2_s0    <= r1_s0;
            r2_c0    <= r1_c0;
            r2_s12   <= r1_s12;

            r3_s0S   <= 33'(rnd30(r2_s0S));
            r3_c0S   <= 33'(rnd30(r2_c0S));
            r3_s0C   <= 33'(rnd30(r2_s0C));
            r3_s0c12 <= 33'(rnd30(r2_s0c12));
            r3_c0C   <= 33'(rnd30(r2_c0C));
            r3_c0c12 <= 33'(rnd30(r2_c0c12));
            r3_bs    <= r2_bs;
            r3_bc    <= r2_bc;
            r3_s0    <= r2_s0;
            r3_c0    <= r2_c0;
            r3_s12   <= r2_s12;

            r4_lc     <= 50'(len_l) * 50'(r3_bc);
            r4_ls     <= 50'(len_l) * 50'(r3_bs);
            r4_ls12   <= 50'(len_l) * 50'(r3_s12);
            r4_ls0S   <= 50'(len_l) * 50'(r3_s0S);
            r4_lc0S   <= 50'(len_l) * 50'(r3_c0S);
            r4_ls0C   <= 50'(len_l) * 50'(r3_s0C);
            r4_ls0c12 <= 50'(len_l) * 50'(r3_s0c12);
            r4_lc0C   <= 50'(len_l) * 50'(r3_c0C);
            r4_lc0c12 <= 50'(len_l) * 50'(r3_c0c12);
            r4_hc0    <= 50'(len_h) * 50'(r3_c0);
            r4_hs0    <= 50'(len_h) * 50'(r3_s0);

            r5_sum[0]  <= -51'(r4_lc);
            r5_sum[1]  <= 51'(r4_hc0) + 51'(r4_ls0S);
            r5_sum[2]  <= 51'(r4_lc0S) - 51'(r4_hs0);
            r5_sum[3]  <= 51'(r4_ls);
            r5_sum[4]  <= 51'(r4_ls12);
            r5_sum[5]  <= 51'(r4_lc0S) - 51'(r4_hs0);
            r5_sum[6]  <= 51'(r4_ls0C);
            r5_sum[7]  <= 51'(r4_ls0c12);
            r5_sum[8]  <= -51'(r4_hc0) - 51'(r4_ls0S);
            r5_sum[9]  <= 51'(r4_lc0C);
            r5_sum[10] <= 51'(r4_lc0c12);

            for (int i = 0; i < N_OUT; i++) begin
                r_res[i] <= sat19(rnd30(64'(r5_sum[i])));
            end
        end
    end

    assign o_res = r_res;

endmodule

### design/leg_fk_chk.sv
// port-level checks for the leg kinematics unit, bound to the top level
// depends on leg_fk_pkg and leg_forward_kinematics_jacobian_unit

module leg_fk_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic [leg_fk_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [leg_fk_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                                i_cfg_valid,
    input logic                                o_cfg_ready,
    input logic [0:0]                          i_cfg_addr,
    input logic [15:0]                         i_cfg_data
);
    import leg_fk_pkg::*;

    // the input side only waits on a full, stalled output
    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    // no result right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

endmodule

bind leg_forward_kinematics_jacobian_unit leg_fk_chk u_leg_fk_chk (.*);
